>>> sv/hevcaud_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HEVC access unit detector package
// Shared types, codes and defaults for the byte parser, the result queue and
// the result serialiser.
// ----------------------------------------------------------------------------
package hevcaud_pkg;

   // Defaults for the top level parameters
   localparam int SizeBitsDefault = 24;
   localparam int MaxUnitsDefault = 1024;

   // Depth of the bundle queue between parser and serialiser
   localparam int QueueDepth = 4;

   // NAL type ranges
   localparam logic [5:0] LAST_SLICE_TYPE = 6'd21;
   localparam logic [5:0] FIRST_PARAM_TYPE = 6'd32;  // VPS
   localparam logic [5:0] LAST_PARAM_TYPE = 6'd35;   // AUD
   localparam logic [5:0] SEI_PREFIX_TYPE = 6'd39;

   // Register reset values
   localparam logic [10:0] MAX_UNITS_RESET = 11'd1024;
   localparam logic [23:0] MAX_SIZE_RESET = 24'hFF_FFFF;

   // Configuration register indexes
   localparam logic [1:0] CSR_LENGTH_PREFIXED = 2'd0;
   localparam logic [1:0] CSR_MAX_UNITS = 2'd1;
   localparam logic [1:0] CSR_MAX_UNIT_SIZE = 2'd2;

   // Result kinds
   localparam logic [1:0] KIND_UNIT = 2'd0;
   localparam logic [1:0] KIND_FRAME = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // Error codes
   localparam logic [1:0] ERR_NONE = 2'd0;
   localparam logic [1:0] ERR_TOO_MANY = 2'd1;
   localparam logic [1:0] ERR_BAD_PREFIX = 2'd2;
   localparam logic [1:0] ERR_TRUNCATED = 2'd3;

   // Parse phase of the open unit
   typedef enum logic [1:0] {
      PHASE_IDLE,
      PHASE_HEADER,
      PHASE_CLASSIFIED
   } phase_type;

   // One stream byte
   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_stream;
   } req_type;

   // One result
   typedef struct packed {
      logic [1:0]  kind;
      logic [5:0]  unit_type;
      logic [23:0] unit_size;
      logic [10:0] unit_count;
      logic [1:0]  error_code;
      logic        last_of_run;
   } rsp_type;

   // Results caused by one byte: one or two
   typedef struct packed {
      logic    two;
      rsp_type res1;
      rsp_type res0;
   } bundle_type;

endpackage

>>> sv/hevc_access_unit_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HEVC access unit detector
// Splits an HEVC elementary stream into NAL units and frames.
// ----------------------------------------------------------------------------
// Usage:
//  req_*  : one stream byte per request, end_of_stream on the final byte.
//  rsp_*  : unit, frame and error results; last_of_run marks the final
//           result caused by a byte. A byte causes zero, one or two results.
//  csr_*  : register writes (mode, unit limit, size limit), always ready;
//           write only while no results are outstanding. Changing the mode
//           drops all parse state.
//  Throughput: one byte per cycle while the bundle queue has room. A byte
//  with two results holds the single-result output register for both, so
//  such bytes drain at one result per cycle through the four-entry bundle
//  queue while rsp_ready is high. Path: the results of an accepted byte
//  enter the bundle queue and then the output register that drives rsp_valid.
//  Stall: when rsp_ready is low the output register holds, the queue fills
//  and req_ready falls once all four bundle slots are taken.
//  Reset: synchronous; clears parse state, queue and output, and restores
//  the register defaults. No clearing pass is needed.
// ----------------------------------------------------------------------------
module hevc_access_unit_detector #(
   parameter int SIZE_BITS = hevcaud_pkg::SizeBitsDefault,
   parameter int MAX_UNITS = hevcaud_pkg::MaxUnitsDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  hevcaud_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output hevcaud_pkg::rsp_type rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [23:0]          csr_data
);

   logic                    q_ready, q_push, q_valid, q_pop;
   hevcaud_pkg::bundle_type q_bundle, q_head;

   assign csr_ready = 1'b1;

   // Parser
   hevcaud_front #(
      .SIZE_BITS(SIZE_BITS),
      .MAX_UNITS(MAX_UNITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .q_ready   (q_ready),
      .q_push    (q_push),
      .q_bundle  (q_bundle)
   );

   // Bundle queue
   hevcaud_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_bundle),
      .push_ready (q_ready),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_data  (q_head)
   );

   // Result serialiser
   hevcaud_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

>>> sv/hevcaud_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HEVC access unit detector: byte parser
// Finds NAL units by start code or length prefix, classifies them into
// frames and writes the results of each byte as one bundle to the queue.
// ----------------------------------------------------------------------------
module hevcaud_front #(
   parameter int SIZE_BITS = hevcaud_pkg::SizeBitsDefault,
   parameter int MAX_UNITS = hevcaud_pkg::MaxUnitsDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  hevcaud_pkg::req_type   req_data,
   input  logic                   csr_valid,
   input  logic [1:0]             csr_index,
   input  logic [23:0]            csr_data,
   input  logic                   q_ready,
   output logic                   q_push,
   output hevcaud_pkg::bundle_type q_bundle
);

   localparam int CntW = ($clog2(MAX_UNITS + 1) > 11) ? $clog2(MAX_UNITS + 1) : 11;
   localparam logic [CntW:0] UnitsCap = (CntW + 1)'(MAX_UNITS);
   localparam logic [23:0] SizeCap =
      (SIZE_BITS >= 24) ? 24'hFF_FFFF : 24'((64'd1 << SIZE_BITS) - 64'd1);

   function automatic logic [23:0] cap_size(input logic [31:0] v);
      return (v > {8'd0, SizeCap}) ? SizeCap : v[23:0];
   endfunction

   function automatic hevcaud_pkg::rsp_type make_res(input logic [1:0] kind,
                                                     input logic [5:0] utype,
                                                     input logic [23:0] usize,
                                                     input logic [10:0] ucount,
                                                     input logic [1:0] code);
      hevcaud_pkg::rsp_type r;
      r.kind = kind;
      r.unit_type = utype;
      r.unit_size = usize;
      r.unit_count = ucount;
      r.error_code = code;
      r.last_of_run = 1'b0;
      return r;
   endfunction

   // Configuration registers
   logic        length_prefixed_ff;
   logic [10:0] max_units_ff;
   logic [23:0] max_size_ff;

   // Parser state
   logic [1:0]             zero_run_ff, zero_run_in;
   logic [1:0]             header_index_ff, header_index_in;
   logic [5:0]             current_type_ff, current_type_in;
   logic [31:0]            byte_counter_ff, byte_counter_in;
   logic                   unit_open_ff, unit_open_in;
   hevcaud_pkg::phase_type phase_ff, phase_in;
   logic                   frame_open_ff, frame_open_in;
   logic [5:0]             frame_type_ff, frame_type_in;
   logic [10:0]            frame_units_ff, frame_units_in;
   logic [23:0]            unit_target_ff, unit_target_in;

   // Working signals of the byte step
   logic                 accept, cfg_clear;
   logic [7:0]           b;
   logic                 eos, sc, hdr, cls, cls_first, len_end, err, starter, param;
   logic [1:0]           idx, err_code, n_res;
   logic [CntW:0]        limit, fu_next;
   hevcaud_pkg::rsp_type res0, res1;

   assign accept = req_valid && q_ready;
   assign req_ready = q_ready;
   assign cfg_clear = csr_valid && (csr_index == hevcaud_pkg::CSR_LENGTH_PREFIXED) &&
                      (csr_data[0] != length_prefixed_ff);
   assign limit = ((CntW + 1)'(max_units_ff) > UnitsCap) ? UnitsCap :
                  (CntW + 1)'(max_units_ff);

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         length_prefixed_ff <= 1'b0;
         max_units_ff <= hevcaud_pkg::MAX_UNITS_RESET;
         max_size_ff <= hevcaud_pkg::MAX_SIZE_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            hevcaud_pkg::CSR_LENGTH_PREFIXED: length_prefixed_ff <= csr_data[0];
            hevcaud_pkg::CSR_MAX_UNITS:       max_units_ff <= csr_data[10:0];
            hevcaud_pkg::CSR_MAX_UNIT_SIZE:   max_size_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // One byte step: worked through in order, as the stream defines it
   always_comb begin
      zero_run_in = zero_run_ff;
      header_index_in = header_index_ff;
      current_type_in = current_type_ff;
      byte_counter_in = byte_counter_ff;
      unit_open_in = unit_open_ff;
      phase_in = phase_ff;
      frame_open_in = frame_open_ff;
      frame_type_in = frame_type_ff;
      frame_units_in = frame_units_ff;
      unit_target_in = unit_target_ff;
      b = req_data.data_byte;
      eos = accept && req_data.end_of_stream;
      sc = 1'b0;
      hdr = 1'b0;
      cls = 1'b0;
      cls_first = 1'b0;
      len_end = 1'b0;
      err = 1'b0;
      err_code = hevcaud_pkg::ERR_NONE;
      starter = 1'b0;
      param = 1'b0;
      idx = header_index_ff;
      fu_next = '0;
      n_res = 2'd0;
      res0 = '0;
      res1 = '0;

      if (accept) begin
         // Delimiting
         if (!length_prefixed_ff) begin
            sc = (b == 8'h01) && (zero_run_ff == 2'd2);
            if (b == 8'h00) begin
               if (zero_run_ff < 2'd2) zero_run_in = zero_run_ff + 2'd1;
            end else begin
               zero_run_in = 2'd0;
            end
            if (unit_open_ff) begin
               if (byte_counter_ff != '1) byte_counter_in = byte_counter_ff + 32'd1;
               hdr = 1'b1;
            end else if (sc && !eos) begin
               unit_open_in = 1'b1;
               phase_in = hevcaud_pkg::PHASE_HEADER;
               header_index_in = 2'd0;
               byte_counter_in = '0;
               current_type_in = '0;
               zero_run_in = 2'd0;
            end
         end else begin
            if (!unit_open_ff) begin
               byte_counter_in = {byte_counter_ff[23:0], b};
               if (header_index_ff == 2'd3) begin
                  if (byte_counter_in == 32'd0 || byte_counter_in > {8'd0, max_size_ff}) begin
                     err = 1'b1;
                     err_code = hevcaud_pkg::ERR_BAD_PREFIX;
                  end else begin
                     unit_target_in = byte_counter_in[23:0];
                     unit_open_in = 1'b1;
                     phase_in = hevcaud_pkg::PHASE_HEADER;
                     header_index_in = 2'd0;
                     byte_counter_in = '0;
                     current_type_in = '0;
                     zero_run_in = 2'd0;
                  end
               end else begin
                  header_index_in = header_index_ff + 2'd1;
               end
            end else begin
               byte_counter_in = byte_counter_ff + 32'd1;
               hdr = 1'b1;
            end
         end

         // Header bytes: type on the first, first_slice_segment on the third
         if (hdr) begin
            idx = header_index_ff;
            if (header_index_ff < 2'd3) header_index_in = header_index_ff + 2'd1;
            if (phase_ff == hevcaud_pkg::PHASE_HEADER) begin
               if (idx == 2'd0) begin
                  current_type_in = b[6:1];
                  if (current_type_in > hevcaud_pkg::LAST_SLICE_TYPE) cls = 1'b1;
               end else if (idx == 2'd2) begin
                  cls = 1'b1;
                  cls_first = b[7];
               end
            end
            // short slice in length mode is classified on its last byte
            len_end = length_prefixed_ff &&
                      (byte_counter_in >= {8'd0, unit_target_ff});
            if (len_end && !cls && phase_ff == hevcaud_pkg::PHASE_HEADER) cls = 1'b1;
         end

         // Classification: frame boundary and unit count
         if (cls) begin
            starter = (current_type_in <= hevcaud_pkg::LAST_SLICE_TYPE) && cls_first;
            param = (current_type_in >= hevcaud_pkg::FIRST_PARAM_TYPE &&
                     current_type_in <= hevcaud_pkg::LAST_PARAM_TYPE) ||
                    (current_type_in == hevcaud_pkg::SEI_PREFIX_TYPE);
            if (frame_open_in && !eos && (param || starter)) begin
               if (n_res < 2'd2) begin
                  if (n_res[0]) res1 = make_res(hevcaud_pkg::KIND_FRAME, frame_type_in, 24'd0,
                                                frame_units_in, hevcaud_pkg::ERR_NONE);
                  else res0 = make_res(hevcaud_pkg::KIND_FRAME, frame_type_in, 24'd0,
                                       frame_units_in, hevcaud_pkg::ERR_NONE);
                  n_res = n_res + 2'd1;
               end
               frame_open_in = 1'b0;
               frame_units_in = '0;
               frame_type_in = '0;
            end
            fu_next = (CntW + 1)'(frame_units_in) + (CntW + 1)'(1);
            if (fu_next > limit) begin
               err = 1'b1;
               err_code = hevcaud_pkg::ERR_TOO_MANY;
            end else begin
               frame_units_in = frame_units_in + 11'd1;
               if (starter && !frame_open_in) begin
                  frame_open_in = 1'b1;
                  frame_type_in = current_type_in;
               end
               phase_in = hevcaud_pkg::PHASE_CLASSIFIED;
            end
         end

         // Unit end
         if (!err && hdr) begin
            if (!length_prefixed_ff && sc) begin
               if (n_res < 2'd2) begin
                  if (n_res[0]) res1 = make_res(hevcaud_pkg::KIND_UNIT, current_type_in,
                                                cap_size(byte_counter_in - 32'd3), 11'd0,
                                                hevcaud_pkg::ERR_NONE);
                  else res0 = make_res(hevcaud_pkg::KIND_UNIT, current_type_in,
                                       cap_size(byte_counter_in - 32'd3), 11'd0,
                                       hevcaud_pkg::ERR_NONE);
                  n_res = n_res + 2'd1;
               end
               unit_open_in = 1'b0;
               phase_in = hevcaud_pkg::PHASE_IDLE;
               if (!eos) begin
                  unit_open_in = 1'b1;
                  phase_in = hevcaud_pkg::PHASE_HEADER;
                  header_index_in = 2'd0;
                  byte_counter_in = '0;
                  current_type_in = '0;
                  zero_run_in = 2'd0;
               end
            end else if (len_end) begin
               if (n_res < 2'd2) begin
                  if (n_res[0]) res1 = make_res(hevcaud_pkg::KIND_UNIT, current_type_in,
                                                cap_size({8'd0, unit_target_ff}), 11'd0,
                                                hevcaud_pkg::ERR_NONE);
                  else res0 = make_res(hevcaud_pkg::KIND_UNIT, current_type_in,
                                       cap_size({8'd0, unit_target_ff}), 11'd0,
                                       hevcaud_pkg::ERR_NONE);
                  n_res = n_res + 2'd1;
               end
               unit_open_in = 1'b0;
               phase_in = hevcaud_pkg::PHASE_IDLE;
               header_index_in = 2'd0;
               byte_counter_in = '0;
            end
         end

         // End of stream closes the open unit and frame
         if (!err && eos) begin
            if (unit_open_in) begin
               if (length_prefixed_ff || phase_in != hevcaud_pkg::PHASE_CLASSIFIED) begin
                  err = 1'b1;
                  err_code = hevcaud_pkg::ERR_TRUNCATED;
               end else begin
                  if (n_res < 2'd2) begin
                     if (n_res[0]) res1 = make_res(hevcaud_pkg::KIND_UNIT, current_type_in,
                                                   cap_size(byte_counter_in), 11'd0,
                                                   hevcaud_pkg::ERR_NONE);
                     else res0 = make_res(hevcaud_pkg::KIND_UNIT, current_type_in,
                                          cap_size(byte_counter_in), 11'd0,
                                          hevcaud_pkg::ERR_NONE);
                     n_res = n_res + 2'd1;
                  end
                  if (frame_open_in && n_res < 2'd2) begin
                     if (n_res[0]) res1 = make_res(hevcaud_pkg::KIND_FRAME, frame_type_in, 24'd0,
                                                   frame_units_in, hevcaud_pkg::ERR_NONE);
                     else res0 = make_res(hevcaud_pkg::KIND_FRAME, frame_type_in, 24'd0,
                                          frame_units_in, hevcaud_pkg::ERR_NONE);
                     n_res = n_res + 2'd1;
                  end
               end
            end else if (length_prefixed_ff && header_index_in != 2'd0) begin
               err = 1'b1;
               err_code = hevcaud_pkg::ERR_TRUNCATED;
            end else if (frame_open_in && n_res < 2'd2) begin
               if (n_res[0]) res1 = make_res(hevcaud_pkg::KIND_FRAME, frame_type_in, 24'd0,
                                             frame_units_in, hevcaud_pkg::ERR_NONE);
               else res0 = make_res(hevcaud_pkg::KIND_FRAME, frame_type_in, 24'd0,
                                    frame_units_in, hevcaud_pkg::ERR_NONE);
               n_res = n_res + 2'd1;
            end
         end

         // Error report
         if (err && n_res < 2'd2) begin
            if (n_res[0]) res1 = make_res(hevcaud_pkg::KIND_ERROR, 6'd0, 24'd0, 11'd0, err_code);
            else res0 = make_res(hevcaud_pkg::KIND_ERROR, 6'd0, 24'd0, 11'd0, err_code);
            n_res = n_res + 2'd1;
         end
      end

      // Error, end of stream or a mode change drop everything
      if (err || eos || cfg_clear) begin
         zero_run_in = 2'd0;
         header_index_in = 2'd0;
         current_type_in = '0;
         byte_counter_in = '0;
         unit_open_in = 1'b0;
         phase_in = hevcaud_pkg::PHASE_IDLE;
         frame_open_in = 1'b0;
         frame_type_in = '0;
         frame_units_in = '0;
         unit_target_in = '0;
      end
   end

   // Bundle to the queue
   assign q_push = accept && (n_res != 2'd0);
   always_comb begin
      q_bundle.two = (n_res == 2'd2);
      q_bundle.res0 = res0;
      q_bundle.res1 = res1;
   end

   // Parser state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         zero_run_ff <= 2'd0;
         header_index_ff <= 2'd0;
         current_type_ff <= '0;
         byte_counter_ff <= '0;
         unit_open_ff <= 1'b0;
         phase_ff <= hevcaud_pkg::PHASE_IDLE;
         frame_open_ff <= 1'b0;
         frame_type_ff <= '0;
         frame_units_ff <= '0;
         unit_target_ff <= '0;
      end else begin
         zero_run_ff <= zero_run_in;
         header_index_ff <= header_index_in;
         current_type_ff <= current_type_in;
         byte_counter_ff <= byte_counter_in;
         unit_open_ff <= unit_open_in;
         phase_ff <= phase_in;
         frame_open_ff <= frame_open_in;
         frame_type_ff <= frame_type_in;
         frame_units_ff <= frame_units_in;
         unit_target_ff <= unit_target_in;
      end
   end

endmodule

>>> sv/hevcaud_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HEVC access unit detector: bundle queue
// Short FIFO of result bundles between the parser and the serialiser.
// ----------------------------------------------------------------------------
module hevcaud_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  hevcaud_pkg::bundle_type push_data,
   output logic                    push_ready,
   input  logic                    pop,
   output logic                    head_valid,
   output hevcaud_pkg::bundle_type head_data
);

   localparam int Depth = hevcaud_pkg::QueueDepth;
   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCount = CntW'(Depth);

   hevcaud_pkg::bundle_type entries_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_pop;

   assign push_ready = (count_ff != FullCount);
   assign head_valid = (count_ff != '0);
   assign head_data = entries_ff[rd_ptr_ff];
   assign do_pop = pop && head_valid;

   // Pointer and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PtrW'(1);
      if (do_pop) rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PtrW'(1);
      if (push && !do_pop) count_in = count_ff + CntW'(1);
      else if (!push && do_pop) count_in = count_ff - CntW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) entries_ff[wr_ptr_ff] <= push_data;
   end

   // Parser only writes when there is room
   assert property (@(posedge clock) disable iff (reset) push |-> push_ready)
      else $error("bundle written to a full queue");

   // Fill level stays within the depth
   assert property (@(posedge clock) disable iff (reset) count_ff <= FullCount)
      else $error("queue fill level out of range");

endmodule

>>> sv/hevcaud_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HEVC access unit detector: result serialiser
// Takes queued bundles and, while rsp_ready is high, delivers their results
// one per cycle through the output register, marking the last of each byte.
// ----------------------------------------------------------------------------
module hevcaud_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   input  hevcaud_pkg::bundle_type q_head,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output hevcaud_pkg::rsp_type    rsp_data
);

   logic                 rsp_valid_ff, rsp_valid_in;
   hevcaud_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic                 half_ff, half_in;
   logic                 load, last;

   assign load = q_valid && (!rsp_valid_ff || rsp_ready);
   assign last = !q_head.two || half_ff;
   assign q_pop = load && last;

   // Pick the next result of the head bundle
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in = rsp_data_ff;
      half_in = half_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in = half_ff ? q_head.res1 : q_head.res0;
         rsp_data_in.last_of_run = last;
         half_in = !last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         half_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         half_ff <= half_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   // The second result of a bundle follows straight after the first
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ready && !rsp_data_ff.last_of_run |=> rsp_valid_ff)
      else $error("second result of a byte not delivered next");

   // While half way through a bundle it must still sit at the head
   assert property (@(posedge clock) disable iff (reset) half_ff |-> q_valid)
      else $error("bundle left the queue before both results went out");

   // An error result always carries a code
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.kind == hevcaud_pkg::KIND_ERROR |->
      rsp_data_ff.error_code != hevcaud_pkg::ERR_NONE)
      else $error("error result without an error code");

endmodule

>>> dv/hevc_access_unit_detector_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HEVC access unit detector test
// Sends byte streams in both framing modes through the request channel and
// checks every unit, frame and error result against a cycle-free model of the
// parser, under several register settings and back-pressure patterns.
// ----------------------------------------------------------------------------
module hevc_access_unit_detector_test;

   localparam int ClockPeriod = 8;
   localparam int ResetCycles = 6;
   localparam int WatchdogLimit = 3000;
   localparam int HoldCycles = 300;
   localparam int SettleCycles = 8;
   localparam int PhaseBytes = 220;
   localparam int MaxUnits = hevcaud_pkg::MaxUnitsDefault;
   localparam logic [23:0] SizeCap = 24'hFF_FFFF;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   hevcaud_pkg::req_type req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   hevcaud_pkg::rsp_type rsp_data;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [1:0]           csr_index;
   logic [23:0]          csr_data;

   // Traffic shaping, shared with the response side
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_asks = 0;
   int hold_seen;
   int hold_left;

   int error_count = 0;
   int quiet_cycles = 0;
   int bytes_sent = 0;

   // Parser model: registers and parse state
   logic                   mode_len;
   logic [10:0]            lim_units;
   logic [23:0]            lim_size;
   int unsigned            zero_run;
   int unsigned            hdr_idx;
   int unsigned            byte_cnt;
   int unsigned            unit_target;
   int unsigned            frame_units;
   logic [5:0]             cur_type;
   logic [5:0]             frame_type;
   logic                   unit_open;
   logic                   frame_open;
   hevcaud_pkg::phase_type phase;

   hevcaud_pkg::rsp_type byte_reports[$];
   hevcaud_pkg::rsp_type nal_reports[$];
   logic [7:0]           stream_bytes[$];

   hevc_access_unit_detector uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #(ClockPeriod / 2) clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Parser model
   // ------------------------------------------------------------------------

   function automatic void note_report(logic [1:0] rkind, logic [5:0] nal_type,
                                       int unsigned nbytes, int unsigned nunits,
                                       logic [1:0] code);
      hevcaud_pkg::rsp_type r;
      if (byte_reports.size() >= 2) return;
      r.kind = rkind;
      r.unit_type = nal_type;
      r.unit_size = (nbytes > SizeCap) ? SizeCap : nbytes[23:0];
      r.unit_count = (nunits > 2047) ? 11'd2047 : nunits[10:0];
      r.error_code = code;
      r.last_of_run = 1'b0;
      byte_reports.push_back(r);
   endfunction

   function automatic void clear_parse();
      zero_run = 0;
      hdr_idx = 0;
      cur_type = '0;
      byte_cnt = 0;
      unit_open = 1'b0;
      phase = hevcaud_pkg::PHASE_IDLE;
      frame_open = 1'b0;
      frame_type = '0;
      frame_units = 0;
      unit_target = 0;
   endfunction

   // Any error drops the open unit and frame
   function automatic void flag_error(logic [1:0] code);
      note_report(hevcaud_pkg::KIND_ERROR, '0, 0, 0, code);
      clear_parse();
   endfunction

   // Decide the frame boundary and count the unit into its frame
   function automatic bit place_unit(bit first, bit eos);
      logic [5:0]  t;
      bit          starter;
      bit          is_param;
      int unsigned limit;
      t = cur_type;
      starter = (t <= hevcaud_pkg::LAST_SLICE_TYPE) && first;
      is_param = (t >= hevcaud_pkg::FIRST_PARAM_TYPE && t <= hevcaud_pkg::LAST_PARAM_TYPE) ||
                 t == hevcaud_pkg::SEI_PREFIX_TYPE;
      limit = (lim_units > MaxUnits) ? MaxUnits : lim_units;
      if (frame_open && !eos && (is_param || starter)) begin
         note_report(hevcaud_pkg::KIND_FRAME, frame_type, 0, frame_units,
                     hevcaud_pkg::ERR_NONE);
         frame_open = 1'b0;
         frame_units = 0;
         frame_type = '0;
      end
      if (frame_units + 1 > limit) begin
         flag_error(hevcaud_pkg::ERR_TOO_MANY);
         return 1'b0;
      end
      frame_units++;
      if (starter && !frame_open) begin
         frame_open = 1'b1;
         frame_type = t;
      end
      phase = hevcaud_pkg::PHASE_CLASSIFIED;
      return 1'b1;
   endfunction

   // Type comes from the first payload byte, first_slice_segment from the third
   function automatic bit scan_header(logic [7:0] b, bit eos);
      int unsigned idx;
      idx = hdr_idx;
      if (hdr_idx < 3) hdr_idx++;
      if (phase != hevcaud_pkg::PHASE_HEADER) return 1'b1;
      if (idx == 0) begin
         cur_type = b[6:1];
         if (cur_type > hevcaud_pkg::LAST_SLICE_TYPE) return place_unit(1'b0, eos);
         return 1'b1;
      end
      if (idx == 2) return place_unit(b[7], eos);
      return 1'b1;
   endfunction

   function automatic void open_unit();
      unit_open = 1'b1;
      phase = hevcaud_pkg::PHASE_HEADER;
      hdr_idx = 0;
      byte_cnt = 0;
      cur_type = '0;
      zero_run = 0;
   endfunction

   function automatic void take_delimited_byte(logic [7:0] b, bit eos);
      bit sc;
      sc = (b == 8'h01) && (zero_run == 2);
      if (b == 8'h00) begin
         if (zero_run < 2) zero_run++;
      end else begin
         zero_run = 0;
      end
      if (unit_open) begin
         if (byte_cnt < 32'hFFFF_FFFF) byte_cnt++;
         if (!scan_header(b, eos)) return;
         // the start code bytes belong to the next unit
         if (sc) begin
            note_report(hevcaud_pkg::KIND_UNIT, cur_type, byte_cnt - 3, 0,
                        hevcaud_pkg::ERR_NONE);
            unit_open = 1'b0;
            phase = hevcaud_pkg::PHASE_IDLE;
            if (!eos) open_unit();
         end
      end else if (sc && !eos) begin
         open_unit();
      end
   endfunction

   function automatic void take_prefixed_byte(logic [7:0] b, bit eos);
      int unsigned prefix;
      // big-endian length prefix
      if (!unit_open) begin
         byte_cnt = (byte_cnt << 8) | b;
         hdr_idx++;
         if (hdr_idx >= 4) begin
            prefix = byte_cnt;
            if (prefix == 0 || prefix > lim_size) begin
               flag_error(hevcaud_pkg::ERR_BAD_PREFIX);
               return;
            end
            open_unit();
            unit_target = prefix;
         end
         return;
      end
      byte_cnt++;
      if (!scan_header(b, eos)) return;
      if (byte_cnt >= unit_target) begin
         // short slice: classified on its last byte as a non-first slice
         if (phase == hevcaud_pkg::PHASE_HEADER && !place_unit(1'b0, eos)) return;
         note_report(hevcaud_pkg::KIND_UNIT, cur_type, unit_target, 0,
                     hevcaud_pkg::ERR_NONE);
         unit_open = 1'b0;
         phase = hevcaud_pkg::PHASE_IDLE;
         hdr_idx = 0;
         byte_cnt = 0;
      end
   endfunction

   function automatic void close_stream();
      if (unit_open) begin
         if (mode_len || phase != hevcaud_pkg::PHASE_CLASSIFIED) begin
            flag_error(hevcaud_pkg::ERR_TRUNCATED);
         end else begin
            note_report(hevcaud_pkg::KIND_UNIT, cur_type, byte_cnt, 0,
                        hevcaud_pkg::ERR_NONE);
            if (frame_open) note_report(hevcaud_pkg::KIND_FRAME, frame_type, 0,
                                        frame_units, hevcaud_pkg::ERR_NONE);
         end
      end else if (mode_len && hdr_idx != 0) begin
         flag_error(hevcaud_pkg::ERR_TRUNCATED);
      end else if (frame_open) begin
         note_report(hevcaud_pkg::KIND_FRAME, frame_type, 0, frame_units,
                     hevcaud_pkg::ERR_NONE);
      end
      clear_parse();
   endfunction

   // Work out the results of one accepted byte and queue them
   function automatic void parse_stream_byte(logic [7:0] b, bit eos);
      hevcaud_pkg::rsp_type r;
      byte_reports.delete();
      if (mode_len) take_prefixed_byte(b, eos);
      else take_delimited_byte(b, eos);
      if (eos) close_stream();
      if (byte_reports.size() > 0) begin
         r = byte_reports.pop_back();
         r.last_of_run = 1'b1;
         byte_reports.push_back(r);
      end
      foreach (byte_reports[i]) nal_reports.push_back(byte_reports[i]);
   endfunction

   function automatic void apply_register(logic [1:0] idx, logic [23:0] value);
      case (idx)
         hevcaud_pkg::CSR_LENGTH_PREFIXED: begin
            // a mode change drops all parse state
            if (value[0] != mode_len) begin
               mode_len = value[0];
               clear_parse();
            end
         end
         hevcaud_pkg::CSR_MAX_UNITS: lim_units = value[10:0];
         hevcaud_pkg::CSR_MAX_UNIT_SIZE: lim_size = value;
         default: ;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------

   task automatic send_byte(input logic [7:0] b, input logic eos);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_valid = 1'b1;
      req_data.data_byte = b;
      req_data.end_of_stream = eos;
      do @(posedge clock); while (!req_ready);
      parse_stream_byte(b, eos);
      bytes_sent++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic send_stream();
      foreach (stream_bytes[i]) send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
   endtask

   // Settle until no result is outstanding and the pipeline is empty
   task automatic wait_drained();
      while (nal_reports.size() != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic write_register(input logic [1:0] idx, input logic [23:0] value);
      wait_drained();
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      apply_register(idx, value);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_config(input logic mode, input int unsigned units,
                             input int unsigned max_size);
      write_register(hevcaud_pkg::CSR_LENGTH_PREFIXED, {23'd0, mode});
      write_register(hevcaud_pkg::CSR_MAX_UNITS, 24'(units));
      write_register(hevcaud_pkg::CSR_MAX_UNIT_SIZE, 24'(max_size));
   endtask

   // ------------------------------------------------------------------------
   // Stream generation
   // ------------------------------------------------------------------------

   // Payload with plenty of zero bytes so that zero runs and stray start codes occur
   function automatic logic [7:0] stream_fill();
      return ($urandom_range(7) == 0) ? 8'h00 : 8'($urandom);
   endfunction

   function automatic logic [5:0] pick_type();
      case ($urandom_range(9))
         0, 1, 2, 3: return 6'($urandom_range(21));
         4: return 6'($urandom_range(32, 34));
         5: return hevcaud_pkg::LAST_PARAM_TYPE;
         6: return hevcaud_pkg::SEI_PREFIX_TYPE;
         default: return 6'($urandom_range(22, 63));
      endcase
   endfunction

   // Append one framed NAL unit to the stream, now and then with a bad prefix
   function automatic void add_nal();
      logic [5:0]  t;
      int unsigned len;
      int unsigned prefix;
      logic [7:0]  body[$];
      t = pick_type();
      len = ($urandom_range(19) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 10);
      body.push_back({1'($urandom), t, 1'($urandom)});
      body.push_back(8'($urandom));
      body.push_back({1'($urandom), 7'($urandom)});
      while (body.size() < len) body.push_back(stream_fill());
      while (body.size() > len) void'(body.pop_back());
      if (mode_len) begin
         prefix = len;
         case ($urandom_range(24))
            0: prefix = 0;
            1: prefix = lim_size + 1;
            default: ;
         endcase
         for (int k = 3; k >= 0; k--) stream_bytes.push_back(8'(prefix >> (8 * k)));
      end else begin
         if ($urandom_range(1) != 0) stream_bytes.push_back(8'h00);
         stream_bytes.push_back(8'h00);
         stream_bytes.push_back(8'h00);
         stream_bytes.push_back(8'h01);
      end
      foreach (body[i]) stream_bytes.push_back(body[i]);
   endfunction

   // Mostly well-formed streams; some carry junk bytes or are cut short
   task automatic send_random_stream();
      int n;
      int keep;
      stream_bytes.delete();
      n = $urandom_range(1, 8);
      for (int u = 0; u < n; u++) begin
         if ($urandom_range(9) == 0) stream_bytes.push_back(8'($urandom));
         add_nal();
      end
      if ($urandom_range(4) == 0) begin
         keep = $urandom_range(1, stream_bytes.size());
         while (stream_bytes.size() > keep) void'(stream_bytes.pop_back());
      end
      send_stream();
   endtask

   task automatic send_noise();
      int n;
      n = $urandom_range(8, 30);
      for (int i = 0; i < n; i++) send_byte(8'($urandom), $urandom_range(15) == 0);
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // VPS, a first slice opening a frame, a slice classified on the final byte
   task automatic test_directed_start_codes();
      stream_bytes = {8'h00, 8'h00, 8'h00, 8'h01, 8'h40,
                      8'h00, 8'h00, 8'h01, 8'h26, 8'h01, 8'hFF,
                      8'h00, 8'h00, 8'h01, 8'h02, 8'h01, 8'h80};
      send_stream();
   endtask

   // Zero prefix, short slice, stream ending inside a prefix
   task automatic test_directed_length_prefix();
      set_config(1'b1, hevcaud_pkg::MAX_UNITS_RESET, hevcaud_pkg::MAX_SIZE_RESET);
      stream_bytes = {8'h00, 8'h00, 8'h00, 8'h00,
                      8'h00, 8'h00, 8'h00, 8'h02, 8'h28, 8'h01,
                      8'h00};
      send_stream();
   endtask

   task automatic test_random_traffic(input logic mode, input int unsigned units,
                                      input int unsigned max_size,
                                      input int idle_pct, input int stall_pct);
      int start;
      set_config(mode, units, max_size);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      start = bytes_sent;
      while (bytes_sent - start < PhaseBytes) begin
         if ($urandom_range(9) == 0) send_noise();
         else send_random_stream();
      end
   endtask

   // Response side held off while short units keep coming, then a full drain
   task automatic test_output_backpressure();
      set_config(1'b0, hevcaud_pkg::MAX_UNITS_RESET, hevcaud_pkg::MAX_SIZE_RESET);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      stream_bytes.delete();
      repeat (40) stream_bytes = {stream_bytes, 8'h00, 8'h00, 8'h01, 8'h40};
      hold_asks++;
      send_stream();
      wait_drained();
   endtask

   // ------------------------------------------------------------------------
   // Response side, checking and watchdog
   // ------------------------------------------------------------------------

   initial begin
      rsp_ready = 1'b0;
      hold_seen = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = HoldCycles;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready = 1'b0;
         end else begin
            rsp_ready = ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin : check_reports
      hevcaud_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (nal_reports.size() == 0) begin
            $error("result with none outstanding: kind %0d type %0d",
                   rsp_data.kind, rsp_data.unit_type);
            error_count++;
         end else begin
            want = nal_reports.pop_front();
            compare_field("kind", want.kind, rsp_data.kind);
            compare_field("unit_type", want.unit_type, rsp_data.unit_type);
            compare_field("unit_size", want.unit_size, rsp_data.unit_size);
            compare_field("unit_count", want.unit_count, rsp_data.unit_count);
            compare_field("error_code", want.error_code, rsp_data.error_code);
            compare_field("last_of_run", want.last_of_run, rsp_data.last_of_run);
         end
      end
   end

   // Counts cycles in which no request, result or register write moves
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = hevcaud_pkg::CSR_LENGTH_PREFIXED;
      csr_data = '0;
      mode_len = 1'b0;
      lim_units = hevcaud_pkg::MAX_UNITS_RESET;
      lim_size = hevcaud_pkg::MAX_SIZE_RESET;
      clear_parse();
      repeat (ResetCycles) @(negedge clock);
      reset = 1'b0;

      test_directed_start_codes();
      test_directed_length_prefix();
      test_random_traffic(1'b0, 1024, 24'hFF_FFFF, 0, 0);
      test_random_traffic(1'b1, 1024, 24'hFF_FFFF, 58, 0);
      test_random_traffic(1'b1, 3, 20, 0, 58);
      test_random_traffic(1'b0, 1, 1, 34, 34);
      test_random_traffic(1'b1, 2, 1, 34, 34);
      test_output_backpressure();

      wait_drained();
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
